// File: hdl/cmdfr_pkg.sv
// Package for the command line framer with XON/XOFF flow control.
// Holds field widths, register and function codes, reset values and the config struct.
// No dependencies; every other file in hdl/ imports it.
`timescale 1ns / 1ps

package cmdfr_pkg;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int FUNC_W     = 2;
    localparam int RD_IDX_W   = 5;
    localparam int LEN_W      = 5;

    // Stream bus widths (fields packed from bit 0, padded to whole bytes)
    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = FUNC_W;
    localparam int M_FIELDS_W = 1 + BYTE_W + 1 + LEN_W + 1 + 1 + BYTE_W;
    localparam int M_TDATA_W  = 32;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // Register port
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_W  = 3;
    localparam int REG_LSB    = 2;

    // Longest length that the length register can report
    localparam logic [LEN_W-1:0] LEN_MAX = 5'd31;

    // Register reset values
    localparam logic             RST_FLOW_EN   = 1'b0;
    localparam logic [BYTE_W-1:0] RST_XON      = 8'd17;
    localparam logic [BYTE_W-1:0] RST_XOFF     = 8'd19;
    localparam logic [BYTE_W-1:0] RST_TERM1    = 8'd13;
    localparam logic [BYTE_W-1:0] RST_TERM2    = 8'd10;

    // Register map, one 32-bit word per register
    typedef enum logic [REG_IDX_W-1:0] {
        REG_FLOW_EN = 3'd0,
        REG_XON     = 3'd1,
        REG_XOFF    = 3'd2,
        REG_TERM1   = 3'd3,
        REG_TERM2   = 3'd4
    } t_reg_idx;

    // Item kinds carried on the input tuser
    typedef enum logic [FUNC_W-1:0] {
        FUNC_RX   = 2'd0,
        FUNC_DONE = 2'd1,
        FUNC_READ = 2'd2
    } t_func;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic              flow_en;
        logic [BYTE_W-1:0] xon;
        logic [BYTE_W-1:0] xoff;
        logic [BYTE_W-1:0] term1;
        logic [BYTE_W-1:0] term2;
    } t_cfg;

endpackage

// File: hdl/command_line_framer_xon_xoff.sv
// Command line framer with XON/XOFF flow control: line buffer, terminator detect, pause tracking.
// An input beat passes the input register, then the result register, on its way to the output.
// Throughput: one item per cycle while m_tready is high; an item that sends two flow bytes
// occupies the output register for two beats, so the output port sets the rate for those items.
// Reset (i_rst_n low, synchronous): registers to defaults, write position, pause flag and
// length to zero, both stages empty; the line buffer is not cleared.
`timescale 1ns / 1ps

module command_line_framer_xon_xoff #(
    parameter int LINE_DEPTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input beats
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] rx_byte, [12:8] read_index, [15:13] zero
    input  logic [cmdfr_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] func
    input  logic [cmdfr_pkg::S_TUSER_W-1:0]  s_tuser,
    // Result beats
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] cmd_ready, [14:10] cmd_length, [15] overflow,
    // [16] pause_requested, [24:17] read_data, [31:25] zero
    output logic [cmdfr_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast,
    // Register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cmdfr_pkg::PADDR_W-1:0]    paddr,
    input  logic [cmdfr_pkg::PDATA_W-1:0]    pwdata,
    output logic [cmdfr_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready
);
    import cmdfr_pkg::*;

    localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int PW = $clog2(LINE_DEPTH + 1);
    localparam int IW = ((AW > RD_IDX_W) ? AW : RD_IDX_W) + 1;
    localparam int LW = ((PW > LEN_W) ? PW : LEN_W) + 1;

    t_cfg w_cfg;

    // Configuration registers
    cmdfr_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    // Input stage
    logic                r_in_valid;
    logic [FUNC_W-1:0]   r_in_func;
    logic [BYTE_W-1:0]   r_in_byte;
    logic [RD_IDX_W-1:0] r_in_idx;

    // Framer state
    logic [BYTE_W-1:0]   r_mem [LINE_DEPTH];
    logic [PW-1:0]       r_pos;
    logic [BYTE_W-1:0]   r_last_byte;
    logic                r_paused;
    logic [LEN_W-1:0]    r_len;
    logic [PW-1:0]       n_pos;
    logic [BYTE_W-1:0]   n_last_byte;
    logic                n_paused;
    logic [LEN_W-1:0]    n_len;

    // Result stage
    logic                r_out_valid;
    logic                r_beat;
    logic                r_two;
    logic                r_txv;
    logic [BYTE_W-1:0]   r_txb;
    logic                r_ready;
    logic                r_ovf;
    logic [LEN_W-1:0]    r_len_o;
    logic                r_paused_o;
    logic                r_rd_en;
    logic [BYTE_W-1:0]   r_rd_data;

    // Datapath
    logic                w_last_beat;
    logic                w_out_free;
    logic                w_advance;
    logic                w_store;
    logic                w_wr_en;
    logic                w_two;
    logic                w_txv;
    logic [BYTE_W-1:0]   w_txb;
    logic                w_ready;
    logic                w_ovf;
    logic                w_rd_en;
    logic [IW-1:0]       w_idx_ext;
    logic [AW-1:0]       w_rd_addr;
    logic [LW-1:0]       w_len_full;
    logic [LEN_W-1:0]    w_len_sat;
    logic                w_tail_t1;

    // Handshake: an input beat waits in the input register while a result is stalled
    assign w_last_beat = !r_two || r_beat;
    assign w_out_free  = !r_out_valid || (m_tready && w_last_beat);
    assign w_advance   = r_in_valid && w_out_free;
    assign s_tready    = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_func <= s_tuser[FUNC_W-1:0];
            r_in_byte <= s_tdata[BYTE_W-1:0];
            r_in_idx  <= s_tdata[BYTE_W +: RD_IDX_W];
        end
    end

    // Length of the ended command: stored bytes before the first terminator, saturated
    assign w_len_full = LW'(r_pos) - LW'(1);
    assign w_len_sat  = (w_len_full > LW'(LEN_MAX)) ? LEN_MAX : w_len_full[LEN_W-1:0];
    // Last stored byte is the first terminator (buffer holds at least one byte)
    assign w_tail_t1  = (r_last_byte == w_cfg.term1);

    // Read index: out-of-range positions read as zero
    assign w_idx_ext  = IW'(r_in_idx);
    assign w_rd_addr  = w_idx_ext[AW-1:0];

    // Item processing
    always_comb begin
        n_pos       = r_pos;
        n_last_byte = r_last_byte;
        n_paused    = r_paused;
        n_len       = r_len;
        w_store     = 1'b0;
        w_wr_en     = 1'b0;
        w_two       = 1'b0;
        w_txv       = 1'b0;
        w_txb       = '0;
        w_ready     = 1'b0;
        w_ovf       = 1'b0;
        w_rd_en     = 1'b0;

        case (r_in_func)
            FUNC_RX: begin
                if (w_cfg.flow_en) begin
                    // Pending pause request: resend XOFF first
                    w_txv = r_paused;
                    if (r_in_byte == w_cfg.xoff) begin
                        n_paused = 1'b1;
                    end else if (r_in_byte == w_cfg.xon) begin
                        n_paused = 1'b0;
                    end else if (r_in_byte == w_cfg.term2) begin
                        if ((r_pos > PW'(2)) && w_tail_t1) begin
                            n_len   = w_len_sat;
                            w_ready = 1'b1;
                            w_two   = r_paused;
                            w_txv   = 1'b1;
                        end
                        n_pos = '0;
                    end else begin
                        w_store = 1'b1;
                    end
                end else begin
                    if (r_in_byte == w_cfg.term2) begin
                        if ((r_pos != '0) && w_tail_t1) begin
                            n_len   = w_len_sat;
                            w_ready = 1'b1;
                            n_pos   = '0;
                        end
                    end else begin
                        w_store = 1'b1;
                    end
                end
                // Store, or flush and flag overflow on a full buffer
                if (w_store) begin
                    if (r_pos < PW'(LINE_DEPTH)) begin
                        w_wr_en     = 1'b1;
                        n_pos       = r_pos + PW'(1);
                        n_last_byte = r_in_byte;
                    end else begin
                        n_pos = '0;
                        w_ovf = 1'b1;
                    end
                end
                w_txb = w_txv ? w_cfg.xoff : '0;
            end
            FUNC_DONE: begin
                n_pos = '0;
                w_txv = w_cfg.flow_en;
                w_txb = w_cfg.flow_en ? w_cfg.xon : '0;
            end
            FUNC_READ: begin
                w_rd_en = (w_idx_ext < IW'(LINE_DEPTH));
            end
            default: ;
        endcase
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_paused <= 1'b0;
            r_len    <= '0;
        end else if (w_advance) begin
            r_pos    <= n_pos;
            r_paused <= n_paused;
            r_len    <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_last_byte <= n_last_byte;
        end
    end

    // Line buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_advance && w_wr_en) begin
            r_mem[r_pos[AW-1:0]] <= r_in_byte;
        end
        if (w_advance) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Result register and beat counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_beat      <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
            r_beat      <= 1'b0;
        end else if (r_out_valid && m_tready) begin
            r_out_valid <= !w_last_beat;
            r_beat      <= !w_last_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_two      <= w_two;
            r_txv      <= w_txv;
            r_txb      <= w_txb;
            r_ready    <= w_ready;
            r_ovf      <= w_ovf;
            r_len_o    <= n_len;
            r_paused_o <= n_paused;
            r_rd_en    <= w_rd_en;
        end
    end

    // Output beat: a pair's first beat sends the resent XOFF; cmd_ready and overflow go on the last
    assign m_tvalid = r_out_valid;
    assign m_tlast  = w_last_beat;
    assign m_tdata  = {
        {M_PAD_W{1'b0}},
        (r_rd_en ? r_rd_data : {BYTE_W{1'b0}}),
        r_paused_o,
        (r_ovf && w_last_beat),
        r_len_o,
        (r_ready && w_last_beat),
        r_txb,
        r_txv
    };

`ifndef ASSERT_OFF
    // Write position never runs past the buffer
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(LINE_DEPTH))
        else $error("write position beyond line buffer");

    // A completed command is reported on the final beat of its item
    a_ready_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[1 + BYTE_W]) |-> m_tlast)
        else $error("cmd_ready on a non-final beat");

    // The first beat of a pair is followed by the final beat, still sending XOFF
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast && m_tdata[0]))
        else $error("second flow byte missing after first beat");

    // A waiting input item blocks the input only while the result side is busy
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |-> !s_tready)
        else $error("input accepted while held item cannot advance");
`endif

endmodule

// File: hdl/cmdfr_regs.sv
// Register file for the command line framer: APB-style write/read port.
// Depends on cmdfr_pkg (register map, reset values, t_cfg).
`timescale 1ns / 1ps

module cmdfr_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [cmdfr_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [cmdfr_pkg::PDATA_W-1:0]  i_pwdata,
    output logic [cmdfr_pkg::PDATA_W-1:0]  o_prdata,
    output logic                           o_pready,
    output cmdfr_pkg::t_cfg                o_cfg
);
    import cmdfr_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign w_idx    = i_paddr[REG_LSB +: REG_IDX_W];
    assign w_wr     = i_psel && i_penable && i_pwrite && o_pready;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    // Register writes; addresses past the map are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flow_en <= RST_FLOW_EN;
            r_cfg.xon     <= RST_XON;
            r_cfg.xoff    <= RST_XOFF;
            r_cfg.term1   <= RST_TERM1;
            r_cfg.term2   <= RST_TERM2;
        end else if (w_wr) begin
            case (w_idx)
                REG_FLOW_EN: r_cfg.flow_en <= i_pwdata[0];
                REG_XON:     r_cfg.xon     <= i_pwdata[BYTE_W-1:0];
                REG_XOFF:    r_cfg.xoff    <= i_pwdata[BYTE_W-1:0];
                REG_TERM1:   r_cfg.term1   <= i_pwdata[BYTE_W-1:0];
                REG_TERM2:   r_cfg.term2   <= i_pwdata[BYTE_W-1:0];
                default:     ;
            endcase
        end
    end

    // Read back
    always_comb begin
        o_prdata = '0;
        case (w_idx)
            REG_FLOW_EN: o_prdata = PDATA_W'(r_cfg.flow_en);
            REG_XON:     o_prdata = PDATA_W'(r_cfg.xon);
            REG_XOFF:    o_prdata = PDATA_W'(r_cfg.xoff);
            REG_TERM1:   o_prdata = PDATA_W'(r_cfg.term1);
            REG_TERM2:   o_prdata = PDATA_W'(r_cfg.term2);
            default:     o_prdata = '0;
        endcase
    end

endmodule

// File: tb/cmdfr_line_checker.sv
// Scoreboard for the command line framer: mirrors the line buffer, pause flag and
// latched length, predicts every result beat and compares the master stream against it.
// Depends on cmdfr_pkg for the register map, item kinds, widths and reset values.
`timescale 1ns / 1ps

module cmdfr_line_checker #(
    parameter int LINE_DEPTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream as seen at the block
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [cmdfr_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic [cmdfr_pkg::S_TUSER_W-1:0]  i_s_tuser,
    // Result stream
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [cmdfr_pkg::M_TDATA_W-1:0]  i_m_tdata,
    input  logic                             i_m_tlast,
    // Register port
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic [cmdfr_pkg::PADDR_W-1:0]    i_paddr,
    input  logic [cmdfr_pkg::PDATA_W-1:0]    i_pwdata,
    input  logic [cmdfr_pkg::PDATA_W-1:0]    i_prdata,
    input  logic                             i_pready,
    output int                               o_fail_count,
    output int                               o_pending
);
    import cmdfr_pkg::*;

    // One result beat, padding bits on top
    typedef struct packed {
        logic [M_PAD_W-1:0] pad;
        logic               tx_valid;
        logic [BYTE_W-1:0]  tx_byte;
        logic               cmd_ready;
        logic [LEN_W-1:0]   cmd_length;
        logic               overflow;
        logic               paused;
        logic [BYTE_W-1:0]  read_data;
        logic               last;
    } t_frame_res;

    // Mirrored block state
    t_cfg              cfg_q;
    logic [BYTE_W-1:0] line_mem [LINE_DEPTH];
    int unsigned       wr_pos;
    logic              paused_q;
    logic [LEN_W-1:0]  len_q;

    t_frame_res        expected_beats [$];
    int                fails;
    int                beats_seen;

    function automatic bit count_fail();
        fails++;
        return fails <= 10;
    endfunction

    function automatic t_frame_res make_res(logic txv, logic [BYTE_W-1:0] txb, logic rdy,
                                            logic ovf, logic [BYTE_W-1:0] rd, logic fin);
        t_frame_res r;
        r.pad        = '0;
        r.tx_valid   = txv;
        r.tx_byte    = txv ? txb : '0;
        r.cmd_ready  = rdy;
        r.cmd_length = len_q;
        r.overflow   = ovf;
        r.paused     = paused_q;
        r.read_data  = rd;
        r.last       = fin;
        return r;
    endfunction

    // Length of the stored line without the first terminator byte, clipped
    function automatic void latch_length();
        len_q = (wr_pos - 1 > LEN_MAX) ? LEN_MAX : LEN_W'(wr_pos - 1);
    endfunction

    // Append to the line; a full line is flushed and reports overflow
    function automatic logic store_rx(logic [BYTE_W-1:0] b);
        if (wr_pos < LINE_DEPTH) begin
            line_mem[wr_pos] = b;
            wr_pos++;
            return 1'b0;
        end
        wr_pos = 0;
        return 1'b1;
    endfunction

    function automatic logic [PDATA_W-1:0] reg_word(logic [PADDR_W-1:0] addr);
        case (t_reg_idx'(addr[PADDR_W-1:REG_LSB]))
            REG_FLOW_EN: return PDATA_W'(cfg_q.flow_en);
            REG_XON:     return PDATA_W'(cfg_q.xon);
            REG_XOFF:    return PDATA_W'(cfg_q.xoff);
            REG_TERM1:   return PDATA_W'(cfg_q.term1);
            REG_TERM2:   return PDATA_W'(cfg_q.term2);
            default:     return '0;
        endcase
    endfunction

    // Work out the result beats of one accepted input beat
    function automatic void predict_item(t_func kind, logic [BYTE_W-1:0] b,
                                         logic [RD_IDX_W-1:0] idx);
        logic resend, line_end, rdy, ovf;
        resend   = 1'b0;
        line_end = 1'b0;
        rdy      = 1'b0;
        ovf      = 1'b0;
        case (kind)
            FUNC_RX: begin
                if (cfg_q.flow_en) begin
                    resend = paused_q;
                    if (b == cfg_q.xoff) begin
                        paused_q = 1'b1;
                    end else if (b == cfg_q.xon) begin
                        paused_q = 1'b0;
                    end else if (b == cfg_q.term2) begin
                        // flow mode needs at least two bytes ahead of the terminator
                        if (wr_pos > 2 && line_mem[wr_pos-1] == cfg_q.term1) begin
                            line_end = 1'b1;
                            rdy      = 1'b1;
                            latch_length();
                        end
                        wr_pos = 0;
                    end else begin
                        ovf = store_rx(b);
                    end
                end else begin
                    // plain mode: a stray second terminator byte is dropped
                    if (b == cfg_q.term2) begin
                        if (wr_pos > 0 && line_mem[wr_pos-1] == cfg_q.term1) begin
                            rdy = 1'b1;
                            latch_length();
                            wr_pos = 0;
                        end
                    end else begin
                        ovf = store_rx(b);
                    end
                end
                if (resend && line_end) begin
                    expected_beats.push_back(make_res(1'b1, cfg_q.xoff, 1'b0, 1'b0, '0, 1'b0));
                    expected_beats.push_back(make_res(1'b1, cfg_q.xoff, rdy, ovf, '0, 1'b1));
                end else begin
                    expected_beats.push_back(make_res(resend || line_end, cfg_q.xoff, rdy, ovf,
                                                      '0, 1'b1));
                end
            end
            FUNC_DONE: begin
                wr_pos = 0;
                expected_beats.push_back(make_res(cfg_q.flow_en, cfg_q.xon, 1'b0, 1'b0,
                                                  '0, 1'b1));
            end
            FUNC_READ: begin
                expected_beats.push_back(make_res(1'b0, '0, 1'b0, 1'b0,
                                                  (idx < LINE_DEPTH) ? line_mem[idx] : '0, 1'b1));
            end
            default: begin
                expected_beats.push_back(make_res(1'b0, '0, 1'b0, 1'b0, '0, 1'b1));
            end
        endcase
    endfunction

    // Watch register port, input and result streams
    always @(posedge i_clk) begin
        t_frame_res want;
        t_frame_res got;
        if (!i_rst_n) begin
            cfg_q    = '{RST_FLOW_EN, RST_XON, RST_XOFF, RST_TERM1, RST_TERM2};
            wr_pos   = 0;
            paused_q = 1'b0;
            len_q    = '0;
            expected_beats.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (t_reg_idx'(i_paddr[PADDR_W-1:REG_LSB]))
                        REG_FLOW_EN: cfg_q.flow_en = i_pwdata[0];
                        REG_XON:     cfg_q.xon     = i_pwdata[BYTE_W-1:0];
                        REG_XOFF:    cfg_q.xoff    = i_pwdata[BYTE_W-1:0];
                        REG_TERM1:   cfg_q.term1   = i_pwdata[BYTE_W-1:0];
                        REG_TERM2:   cfg_q.term2   = i_pwdata[BYTE_W-1:0];
                        default: ;
                    endcase
                end else if (i_prdata !== reg_word(i_paddr)) begin
                    if (count_fail())
                        $display("register read at %0h: expected %08h, got %08h",
                                 i_paddr, reg_word(i_paddr), i_prdata);
                end
            end

            if (i_s_tvalid && i_s_tready)
                predict_item(t_func'(i_s_tuser), i_s_tdata[BYTE_W-1:0],
                             i_s_tdata[BYTE_W +: RD_IDX_W]);

            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[M_TDATA_W-1:M_FIELDS_W], i_m_tdata[0], i_m_tdata[8:1],
                       i_m_tdata[9], i_m_tdata[14:10], i_m_tdata[15], i_m_tdata[16],
                       i_m_tdata[24:17], i_m_tlast};
                if (expected_beats.size() == 0) begin
                    if (count_fail())
                        $display("result beat %0d arrived with nothing expected", beats_seen);
                end else begin
                    want = expected_beats.pop_front();
                    if (got !== want && count_fail())
                        $display({"result beat %0d: expected txv=%0b txb=%02h rdy=%0b len=%0d ",
                                  "ovf=%0b pause=%0b rd=%02h last=%0b pad=%0h, got txv=%0b ",
                                  "txb=%02h rdy=%0b len=%0d ovf=%0b pause=%0b rd=%02h last=%0b ",
                                  "pad=%0h"},
                                 beats_seen, want.tx_valid, want.tx_byte, want.cmd_ready,
                                 want.cmd_length, want.overflow, want.paused, want.read_data,
                                 want.last, want.pad, got.tx_valid, got.tx_byte, got.cmd_ready,
                                 got.cmd_length, got.overflow, got.paused, got.read_data,
                                 got.last, got.pad);
                end
                beats_seen++;
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_beats.size();
    end

endmodule

// File: tb/tb.sv
// Top of the framer testbench: clock, reset, register setup and stream traffic.
// Depends on cmdfr_pkg, the framer RTL and cmdfr_line_checker, which does all checking.
`timescale 1ns / 1ps

module tb;
    import cmdfr_pkg::*;

    localparam int LINE_DEPTH     = 32;
    localparam int STALL_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_BEATS    = 84;
    // Item kind the block does not use; it answers with an idle beat
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int   fail_count;
    int   pending;
    bit   quiet       = 1'b0;
    int   stall_left  = 0;
    int   beats_sent  = 0;
    int   idle_cycles = 0;
    t_cfg cfg_now     = '{RST_FLOW_EN, RST_XON, RST_XOFF, RST_TERM1, RST_TERM2};

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    command_line_framer_xon_xoff #(
        .LINE_DEPTH(LINE_DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    cmdfr_line_checker #(
        .LINE_DEPTH(LINE_DEPTH)
    ) line_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: random back-pressure, or a counted hold-off when requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= quiet || ($urandom_range(99) >= 11);
            end
        end
    end

    // Watchdog on cycles without any beat or register access
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("command_line_framer_xon_xoff: mismatch");
            $finish;
        end
    end

    // One input beat, with random gaps ahead of it
    task automatic send_beat(logic [FUNC_W-1:0] kind, logic [BYTE_W-1:0] rx,
                             logic [RD_IDX_W-1:0] idx);
        if (!quiet) begin
            while ($urandom_range(99) < 11) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, idx, rx};
        do @(posedge i_clk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic send_rx(logic [BYTE_W-1:0] b);
        send_beat(FUNC_RX, b, RD_IDX_W'($urandom));
    endtask

    // Stop offering and wait until every expected result beat is out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_access(bit wr, t_reg_idx r, logic [PDATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {r, 2'b00};
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_regs();
        t_reg_idx r;
        r = r.first;
        repeat (r.num) begin
            apb_access(1'b0, r, '0);
            r = r.next;
        end
    endtask

    task automatic set_regs(t_cfg c);
        apb_access(1'b1, REG_FLOW_EN, PDATA_W'(c.flow_en));
        apb_access(1'b1, REG_XON,     PDATA_W'(c.xon));
        apb_access(1'b1, REG_XOFF,    PDATA_W'(c.xoff));
        apb_access(1'b1, REG_TERM1,   PDATA_W'(c.term1));
        apb_access(1'b1, REG_TERM2,   PDATA_W'(c.term2));
        cfg_now = c;
        read_regs();
    endtask

    // Mostly terminated lines with random content, mixed with reads, flushes and noise
    task automatic random_traffic(int n);
        int               stop_at;
        int               pick;
        int               body;
        logic [BYTE_W-1:0] b;
        stop_at = beats_sent + n;
        while (beats_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                // a few lines run past the end of the buffer
                body = ($urandom_range(14) == 0) ? $urandom_range(36, 28) : $urandom_range(8, 0);
                for (int i = 0; i < body; i++) begin
                    if (cfg_now.flow_en && $urandom_range(9) == 0)
                        send_rx($urandom_range(1) ? cfg_now.xoff : cfg_now.xon);
                    b = BYTE_W'($urandom);
                    repeat (16) begin
                        if (b == cfg_now.xon || b == cfg_now.xoff || b == cfg_now.term1 ||
                            b == cfg_now.term2)
                            b = BYTE_W'($urandom);
                    end
                    send_rx(b);
                end
                send_rx(cfg_now.term1);
                send_rx(cfg_now.term2);
            end else if (pick < 70) begin
                send_beat(FUNC_READ, BYTE_W'($urandom), RD_IDX_W'($urandom));
            end else if (pick < 76) begin
                send_beat(FUNC_DONE, BYTE_W'($urandom), RD_IDX_W'($urandom));
            end else if (pick < 79) begin
                send_beat(FUNC_SPARE, BYTE_W'($urandom), RD_IDX_W'($urandom));
            end else if (pick < 83) begin
                send_rx(cfg_now.term2);
            end else if (pick < 88) begin
                send_rx(cfg_now.term1);
            end else begin
                send_rx(BYTE_W'($urandom));
            end
        end
    endtask

    initial begin
        t_cfg c;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_regs();

        // Fill every buffer entry once, then one byte too many to force overflow
        for (int i = 0; i < LINE_DEPTH; i++)
            send_rx((i == 0) ? 8'h00 : (i == 1) ? 8'hFF : BYTE_W'(8'h20 + i));
        send_rx(8'h41);
        send_beat(FUNC_READ, 8'h00, 5'd0);
        send_beat(FUNC_READ, 8'hFF, 5'd31);
        // plain mode: short command, stray terminator, empty command
        send_rx(8'h41);
        send_rx(8'h42);
        send_rx(RST_TERM1);
        send_rx(RST_TERM2);
        send_rx(RST_TERM2);
        send_rx(RST_TERM1);
        send_rx(RST_TERM2);
        send_beat(FUNC_DONE, 8'h00, 5'd0);
        send_beat(FUNC_SPARE, 8'hFF, 5'd31);
        drain();

        // Flow mode: pause request, XOFF resent ahead of the end XOFF, too-short line
        set_regs('{1'b1, RST_XON, RST_XOFF, RST_TERM1, RST_TERM2});
        send_rx(RST_XOFF);
        send_rx(8'h41);
        send_rx(8'h42);
        send_rx(RST_TERM1);
        send_rx(RST_TERM2);
        send_rx(RST_XON);
        send_rx(8'h78);
        send_rx(RST_TERM1);
        send_rx(RST_TERM2);
        send_beat(FUNC_DONE, 8'h00, 5'd0);
        send_beat(FUNC_READ, 8'h00, 5'd1);
        drain();

        // Random phases over several register settings, extremes among them
        for (int phase = 0; phase < 8; phase++) begin
            c.flow_en = 1'b1;
            c.xon     = BYTE_W'($urandom);
            c.xoff    = BYTE_W'($urandom);
            c.term1   = BYTE_W'($urandom);
            c.term2   = BYTE_W'($urandom);
            case (phase)
                0: c = '{1'b1, RST_XON, RST_XOFF, RST_TERM1, RST_TERM2};
                1: c = '{1'b0, RST_XON, RST_XOFF, RST_TERM1, RST_TERM2};
                2: c = '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00};
                3: c = '{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
                4: begin
                    // same code for resume, pause and line end
                    c.xoff  = c.xon;
                    c.term2 = c.xon;
                end
                6: c.flow_en = 1'b0;
                default: ;
            endcase
            set_regs(c);
            // long receiver hold-off while the sender keeps offering beats
            if (phase == 0)
                stall_left = STALL_CYCLES;
            quiet = (phase == 1);
            random_traffic(PHASE_BEATS);
            quiet = 1'b0;
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("command_line_framer_xon_xoff: match");
        else
            $display("command_line_framer_xon_xoff: mismatch");
        $finish;
    end

endmodule

// File: files.f
hdl/cmdfr_pkg.sv
hdl/cmdfr_regs.sv
hdl/command_line_framer_xon_xoff.sv
tb/cmdfr_line_checker.sv
tb/tb.sv
